// File: sv/lap4_pkg.sv
// Package for the fourth-order 3D Laplacian stencil engine.
// Holds grid constants, register index codes, line buffer entry type and the
// per-axis stencil term. No dependencies.
`default_nettype none

package lap4_pkg;

  localparam int MAX_GRID_X  = 64;
  localparam int MAX_GRID_Y  = 64;
  localparam int MAX_GRID_Z  = 64;
  localparam int SAMPLE_BITS = 32;

  // padded plane geometry
  localparam int ROW_LEN    = MAX_GRID_Z + 4;
  localparam int NUM_ROWS   = MAX_GRID_Y + 4;
  localparam int PLANE_LEN  = NUM_ROWS * ROW_LEN;
  localparam int STORE_AW   = $clog2(PLANE_LEN);
  localparam int LINE_DEPTH = ROW_LEN + 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);

  localparam int DIM_W   = 7;
  localparam int POS_W   = 7;
  localparam int COEF_W  = 32;
  localparam int TERM_W  = 39;
  localparam int PROD_W  = 56;
  localparam int SUM_W   = 58;
  localparam int LAP_W   = 56;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_X = 3'd0,
    CFG_GRID_Y = 3'd1,
    CFG_GRID_Z = 3'd2,
    CFG_COEF_X = 3'd3,
    CFG_COEF_Y = 3'd4,
    CFG_COEF_Z = 3'd5
  } cfg_idx_e;

  // One line buffer entry: center plane samples at one z column
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] m2;  // row y-2
    logic signed [SAMPLE_BITS-1:0] m1;  // row y-1
    logic signed [SAMPLE_BITS-1:0] c0;  // row y
    logic signed [SAMPLE_BITS-1:0] n1;  // row y+1
  } line_t;

  // 16*(m1+p1) - (m2+p2) - 30*c
  function automatic logic signed [TERM_W-1:0] axis_term(
    input logic signed [SAMPLE_BITS-1:0] m1,
    input logic signed [SAMPLE_BITS-1:0] p1,
    input logic signed [SAMPLE_BITS-1:0] m2,
    input logic signed [SAMPLE_BITS-1:0] p2,
    input logic signed [SAMPLE_BITS-1:0] c
  );
    logic signed [TERM_W-1:0] near_s;
    logic signed [TERM_W-1:0] far_s;
    logic signed [TERM_W-1:0] ctr;
    near_s = TERM_W'(m1) + TERM_W'(p1);
    far_s  = TERM_W'(m2) + TERM_W'(p2);
    ctr    = TERM_W'(c);
    return (near_s <<< 4) - far_s - ((ctr <<< 5) - (ctr <<< 1));
  endfunction

endpackage

`default_nettype wire

// File: sv/laplacian_4th_order_stencil_3d.sv
// Top level of the fourth-order 3D Laplacian stencil engine.
// Depends on lap4_pkg (constants, register codes, line entry, axis term).
//
// Usage: padded samples enter on the in channel (valid/ready), z fastest,
// then y, then x. One result per interior point leaves on the out channel
// (valid/ready) with final_point set on the last interior point of a grid.
// Configuration writes go through the cfg channel (always ready); writing a
// grid dimension restarts the stream at the padded origin.
// Throughput: one sample per cycle while the output is not stalled. Pipeline:
// the result of a stencil is registered through read and axis terms, products,
// sums and the output register after the sample that completes it is taken.
// Storage: four plane banks with one write and two read ports each, read on
// the cycle a sample is taken, plus a line buffer of center-plane rows that
// is read when a sample is taken and written back when it leaves stage 1;
// this read-then-write schedule is what sets the one-sample-per-cycle rate.
// Reset: position and grid registers return to the origin / defaults,
// pipeline valids clear; sample memories are not cleared.
// Stall: the pipeline is elastic; in_ready_o drops only when every stage
// holds a request and the output register is not being drained.
`default_nettype none

module laplacian_4th_order_stencil_3d (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire signed [lap4_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic signed [lap4_pkg::LAP_W-1:0]   laplacian_o,
  output logic                                final_point_o,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire [lap4_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire [lap4_pkg::COEF_W-1:0]          cfg_data_i
);
  import lap4_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

  // ---------------- configuration ----------------
  logic [DIM_W-1:0]  grid_x_q, grid_y_q, grid_z_q;
  logic [COEF_W-1:0] coef_x_q, coef_y_q, coef_z_q;
  logic              cfg_wr;
  logic              restart;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;
  assign restart     = cfg_wr && (cfg_index_i == CFG_GRID_X || cfg_index_i == CFG_GRID_Y
                                  || cfg_index_i == CFG_GRID_Z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_x_q <= DIM_W'(MAX_GRID_X);
      grid_y_q <= DIM_W'(MAX_GRID_Y);
      grid_z_q <= DIM_W'(MAX_GRID_Z);
      coef_x_q <= COEF_W'(65536);
      coef_y_q <= COEF_W'(65536);
      coef_z_q <= COEF_W'(65536);
    end else if (cfg_wr) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GRID_X: grid_x_q <= clamp_dim(cfg_data_i[DIM_W-1:0], DIM_W'(MAX_GRID_X));
        CFG_GRID_Y: grid_y_q <= clamp_dim(cfg_data_i[DIM_W-1:0], DIM_W'(MAX_GRID_Y));
        CFG_GRID_Z: grid_z_q <= clamp_dim(cfg_data_i[DIM_W-1:0], DIM_W'(MAX_GRID_Z));
        CFG_COEF_X: coef_x_q <= cfg_data_i;
        CFG_COEF_Y: coef_y_q <= cfg_data_i;
        CFG_COEF_Z: coef_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline flow control ----------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic s1_emit_q;
  logic out_free, s4_free, s3_free, s2_free, s1_move, s1_free;
  logic accept;

  assign out_free   = !out_v_q || out_ready_i;
  assign s4_free    = !s4_v_q || out_free;
  assign s3_free    = !s3_v_q || s4_free;
  assign s2_free    = !s2_v_q || s3_free;
  assign s1_move    = s1_v_q && (!s1_emit_q || s2_free);
  assign s1_free    = !s1_v_q || s1_move;
  assign in_ready_o = s1_free;
  assign accept     = in_valid_i && s1_free;

  // ---------------- stream position ----------------
  logic [POS_W-1:0] px_q, py_q, pz_q;
  logic [POS_W:0]   pz_inc, py_inc, px_inc;

  assign pz_inc = {1'b0, pz_q} + 1'b1;
  assign py_inc = {1'b0, py_q} + 1'b1;
  assign px_inc = {1'b0, px_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      py_q <= '0;
      pz_q <= '0;
    end else if (restart) begin
      px_q <= '0;
      py_q <= '0;
      pz_q <= '0;
    end else if (accept) begin
      if (pz_inc >= ({1'b0, grid_z_q} + (POS_W+1)'(4))) begin
        pz_q <= '0;
        if (py_inc >= ({1'b0, grid_y_q} + (POS_W+1)'(4))) begin
          py_q <= '0;
          if (px_inc >= ({1'b0, grid_x_q} + (POS_W+1)'(4))) px_q <= '0;
          else px_q <= px_inc[POS_W-1:0];
        end else begin
          py_q <= py_inc[POS_W-1:0];
        end
      end else begin
        pz_q <= pz_inc[POS_W-1:0];
      end
    end
  end

  // interior test and last-point flag for the current position
  logic [POS_W:0] py_ext, pz_ext;
  logic           emit_now, final_now;

  assign py_ext    = {1'b0, py_q};
  assign pz_ext    = {1'b0, pz_q};
  assign emit_now  = (px_q >= POS_W'(4)) && (py_q >= POS_W'(2))
                  && (py_ext < {1'b0, grid_y_q} + (POS_W+1)'(2))
                  && (pz_q >= POS_W'(2))
                  && (pz_ext < {1'b0, grid_z_q} + (POS_W+1)'(2));
  assign final_now = ({1'b0, px_q} == {1'b0, grid_x_q} + (POS_W+1)'(3))
                  && (py_ext == {1'b0, grid_y_q} + (POS_W+1)'(1))
                  && (pz_ext == {1'b0, grid_z_q} + (POS_W+1)'(1));

  // ---------------- plane store: four banks, ring by x mod 4 ----------------
  logic [STORE_AW-1:0] addr_a, addr_b;
  logic [POS_W:0]      yb;
  logic [POS_W-1:0]    yb_row;
  smp_t                rd_a [4];
  smp_t                rd_b [4];

  assign yb     = py_ext + (POS_W+1)'(2);
  assign yb_row = (yb >= (POS_W+1)'(NUM_ROWS)) ? py_q : yb[POS_W-1:0];
  assign addr_a = STORE_AW'(py_q * ROW_LEN + pz_q);
  assign addr_b = STORE_AW'(yb_row * ROW_LEN + pz_q);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    smp_t bank_mem [PLANE_LEN];
    always_ff @(posedge clk_i) begin
      if (accept) begin
        rd_a[b] <= bank_mem[addr_a];
        rd_b[b] <= bank_mem[addr_b];
        if (px_q[1:0] == 2'(b)) bank_mem[addr_a] <= sample_i;
      end
    end
  end

  // ---------------- line buffer of center plane rows ----------------
  line_t              line_mem [LINE_DEPTH];
  line_t              la_rd, lb_rd, line_wr;
  logic [LINE_AW-1:0] la_addr, lb_addr;
  logic [LINE_AW-1:0] s1_pz_q;

  assign la_addr = LINE_AW'(pz_q);
  assign lb_addr = LINE_AW'(pz_ext + (POS_W+1)'(2));

  always_ff @(posedge clk_i) begin
    if (accept) begin
      la_rd <= line_mem[la_addr];
      lb_rd <= line_mem[lb_addr];
    end
    if (s1_move) line_mem[s1_pz_q] <= line_wr;
  end

  // ---------------- stage 1: gather neighbors, axis terms ----------------
  logic [1:0]         s1_slot_q;
  smp_t               s1_smp_q;
  logic               s1_final_q;
  smp_t               zm1_q, zm2_q, zp1_q;
  smp_t               c_v, xm1, xm2, xp1, yp2;
  logic signed [TERM_W-1:0] tx, ty, tz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s1_emit_q <= 1'b0;
    end else if (s1_free) begin
      s1_v_q    <= accept;
      s1_emit_q <= emit_now;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pz_q    <= la_addr;
      s1_slot_q  <= px_q[1:0];
      s1_smp_q   <= sample_i;
      s1_final_q <= final_now;
    end
    // z window along the current row
    if (s1_move) begin
      zm2_q <= zm1_q;
      zm1_q <= c_v;
      zp1_q <= lb_rd.c0;
    end
  end

  assign xm2 = rd_a[s1_slot_q];
  assign xm1 = rd_a[s1_slot_q - 2'd1];
  assign c_v = rd_a[s1_slot_q - 2'd2];
  assign xp1 = rd_a[s1_slot_q - 2'd3];
  assign yp2 = rd_b[s1_slot_q - 2'd2];

  assign tx = axis_term(xm1, xp1, xm2, s1_smp_q, c_v);
  assign ty = axis_term(la_rd.m1, la_rd.n1, la_rd.m2, yp2, c_v);
  assign tz = axis_term(zm1_q, zp1_q, zm2_q, lb_rd.c0, c_v);

  // shift the column history down one row
  always_comb begin
    line_wr.m2 = la_rd.m1;
    line_wr.m1 = c_v;
    line_wr.c0 = la_rd.n1;
    line_wr.n1 = yp2;
  end

  // ---------------- stage 2: registered axis terms ----------------
  logic signed [TERM_W-1:0] s2_t_q [3];
  logic                     s2_final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (s2_free) s2_v_q <= s1_v_q && s1_emit_q;
  end

  always_ff @(posedge clk_i) begin
    if (s2_free) begin
      s2_t_q[0]  <= tx;
      s2_t_q[1]  <= ty;
      s2_t_q[2]  <= tz;
      s2_final_q <= s1_final_q;
    end
  end

  // ---------------- stage 3: products with coefficient halves ----------------
  logic signed [PROD_W-1:0] s3_hi_q [3];
  logic signed [PROD_W-1:0] s3_lo_q [3];
  logic                     s3_final_q;
  logic [COEF_W-1:0]        coefs [3];

  assign coefs[0] = coef_x_q;
  assign coefs[1] = coef_y_q;
  assign coefs[2] = coef_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (s3_free) s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (s3_free) begin
      for (int a = 0; a < 3; a++) begin
        s3_hi_q[a] <= PROD_W'(s2_t_q[a]) * PROD_W'($signed({1'b0, coefs[a][31:16]}));
        s3_lo_q[a] <= PROD_W'(s2_t_q[a]) * PROD_W'($signed({1'b0, coefs[a][15:0]}));
      end
      s3_final_q <= s2_final_q;
    end
  end

  // ---------------- stage 4: sums of high and low parts ----------------
  logic signed [SUM_W-1:0] s4_hi_q, s4_lo_q;
  logic                    s4_final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (s4_free) s4_v_q <= s3_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (s4_free) begin
      s4_hi_q    <= SUM_W'(s3_hi_q[0]) + SUM_W'(s3_hi_q[1]) + SUM_W'(s3_hi_q[2]);
      s4_lo_q    <= SUM_W'(s3_lo_q[0]) + SUM_W'(s3_lo_q[1]) + SUM_W'(s3_lo_q[2]);
      s4_final_q <= s3_final_q;
    end
  end

  // ---------------- output register ----------------
  logic signed [SUM_W-1:0] result;
  logic signed [LAP_W-1:0] lap_q;
  logic                    final_q;

  // floor shift of the low part, then join
  assign result = s4_hi_q + (s4_lo_q >>> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (out_free) out_v_q <= s4_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      lap_q   <= result[LAP_W-1:0];
      final_q <= s4_final_q;
    end
  end

  assign out_valid_o   = out_v_q;
  assign laplacian_o   = lap_q;
  assign final_point_o = final_q;

endmodule

`default_nettype wire

// File: tb/laplacian_4th_order_stencil_3d_test.sv
// Self-checking testbench for the fourth-order 3D Laplacian stencil engine.
// Streams padded grids of several shapes and coefficient sets, predicts each
// stencil result in a scoreboard class. Depends on lap4_pkg and the DUT.
`default_nettype none

module laplacian_4th_order_stencil_3d_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lap4_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam int RANDOM_SAMPLES = 600;
  localparam int CYCLE_LIMIT    = 3000000;

  typedef struct {
    logic signed [LAP_W-1:0] lap;
    logic                    fin;
  } lap_result_t;

  // Stencil predictor plus the queue of pending results
  class lap_scoreboard;
    int                 planes[4][NUM_ROWS][ROW_LEN];
    int                 px, py, pz;
    int                 gx, gy, gz;
    bit [COEF_W-1:0]    kx, ky, kz;
    lap_result_t        pending[$];
    int                 mismatches;
    int                 results_seen;

    function new();
      gx = MAX_GRID_X; gy = MAX_GRID_Y; gz = MAX_GRID_Z;
      kx = 32'h10000; ky = 32'h10000; kz = 32'h10000;
    endfunction

    function int clamp_dim(bit [COEF_W-1:0] v, int maxv);
      int d;
      d = int'(v[DIM_W-1:0]);
      if (d == 0) return 1;
      if (d > maxv) return maxv;
      return d;
    endfunction

    function longint at(int x, int y, int z);
      return longint'(planes[x & 3][y][z]);
    endfunction

    function longint term(longint m1, longint p1, longint m2, longint p2, longint c);
      return 16 * (m1 + p1) - (m2 + p2) - 30 * c;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, bit [COEF_W-1:0] v);
      case (idx)
        CFG_GRID_X: gx = clamp_dim(v, MAX_GRID_X);
        CFG_GRID_Y: gy = clamp_dim(v, MAX_GRID_Y);
        CFG_GRID_Z: gz = clamp_dim(v, MAX_GRID_Z);
        CFG_COEF_X: kx = v;
        CFG_COEF_Y: ky = v;
        CFG_COEF_Z: kz = v;
        default: ;
      endcase
      // any grid dimension write restarts at the padded origin
      if (idx == CFG_GRID_X || idx == CFG_GRID_Y || idx == CFG_GRID_Z) begin
        px = 0; py = 0; pz = 0;
      end
    endfunction

    function void note_sample(int s);
      int          cx;
      longint      c, tx, ty, tz, hi, lo;
      lap_result_t r;
      if (px >= 4 && py >= 2 && py < gy + 2 && pz >= 2 && pz < gz + 2) begin
        cx = px - 2;
        c  = at(cx, py, pz);
        tx = term(at(cx - 1, py, pz), at(cx + 1, py, pz), at(cx - 2, py, pz),
                  longint'(s), c);
        ty = term(at(cx, py - 1, pz), at(cx, py + 1, pz), at(cx, py - 2, pz),
                  at(cx, py + 2, pz), c);
        tz = term(at(cx, py, pz - 1), at(cx, py, pz + 1), at(cx, py, pz - 2),
                  at(cx, py, pz + 2), c);
        hi = tx * longint'(kx[31:16]) + ty * longint'(ky[31:16]) + tz * longint'(kz[31:16]);
        lo = tx * longint'(kx[15:0]) + ty * longint'(ky[15:0]) + tz * longint'(kz[15:0]);
        r.lap = LAP_W'(hi + (lo >>> 16));
        r.fin = (cx == gx + 1 && py == gy + 1 && pz == gz + 1);
        pending.push_back(r);
      end
      planes[px & 3][py][pz] = s;
      // advance z, then y, then x through the padded grid
      pz++;
      if (pz >= gz + 4) begin
        pz = 0;
        py++;
        if (py >= gy + 4) begin
          py = 0;
          px++;
          if (px >= gx + 4) px = 0;
        end
      end
    endfunction

    function void check(logic signed [LAP_W-1:0] lap, logic fin);
      lap_result_t e;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result lap=%0d final=%0b", lap, fin);
        return;
      end
      e = pending.pop_front();
      if (lap !== e.lap || fin !== e.fin) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected lap=%0d final=%0b, got lap=%0d final=%0b",
                   results_seen, e.lap, e.fin, lap, fin);
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic signed [SAMPLE_BITS-1:0] sample_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b1;
  logic signed [LAP_W-1:0] laplacian_o;
  logic                    final_point_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [COEF_W-1:0]       cfg_data_i = '0;

  lap_scoreboard sb = new();
  bit            calm;
  int            stall_left;
  int            cycles;
  int            samples_sent;
  int            settings_used;

  laplacian_4th_order_stencil_3d DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", sb.pending.size());
      $display("[laplacian_4th_order_stencil_3d] ERROR");
      $finish;
    end
  end

  // result side: burst stalls until the calm tail
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check(laplacian_o, final_point_o);
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic put_sample(int s);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(s);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, v);
    @(negedge clk_i);
  endtask

  // wait for every result, then let the pipeline settle
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_grid(int x, int y, int z, logic [31:0] ax, logic [31:0] ay,
                          logic [31:0] az);
    drain();
    put_reg(CFG_GRID_X, x);
    put_reg(CFG_GRID_Y, y);
    put_reg(CFG_GRID_Z, z);
    put_reg(CFG_COEF_X, ax);
    put_reg(CFG_COEF_Y, ay);
    put_reg(CFG_COEF_Z, az);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    settings_used++;
  endtask

  function automatic int pick_sample();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h10000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 127;
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  task automatic stream(int n);
    repeat (n) put_sample(pick_sample());
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    int n;
    int total;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // single interior point with extreme samples
    set_grid(1, 1, 1, 32'h10000, 32'h10000, 32'h10000);
    for (int i = 0; i < 125; i++) begin
      case (i % 4)
        0: put_sample(32'h7FFF_FFFF);
        1: put_sample(32'h8000_0000);
        2: put_sample(0);
        default: put_sample(-1);
      endcase
    end
    in_valid_i <= 1'b0;
    @(negedge clk_i);

    // oversized x extent clamps to the maximum, zero extents clamp to one
    set_grid(100, 0, 0, 32'hFFFF_FFFF, 32'h0, 32'h3039);
    stream(400);

    // unused register indexes, then a coefficient change mid-grid
    set_grid(2, 2, 2, 32'h10000, 32'h20000, 32'h8000);
    put_reg(CFG_SPARE_A, 32'hDEAD_BEEF);
    put_reg(CFG_SPARE_B, 32'h0);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    stream(120);
    drain();
    put_reg(CFG_COEF_Y, 32'h1234_5678);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    stream(216 + 100);

    // random grids: mostly whole grids, some cut short and restarted
    n = 0;
    while (n < RANDOM_SAMPLES) begin
      set_grid(pick_dim(), pick_dim(), pick_dim(), pick_coef(), pick_coef(), pick_coef());
      total = (sb.gx + 4) * (sb.gy + 4) * (sb.gz + 4);
      if ($urandom_range(0, 4) == 0) total = $urandom_range(1, total);
      else if (total < 400 && $urandom_range(0, 2) == 0) total = 2 * total;
      if (total > RANDOM_SAMPLES - n) total = RANDOM_SAMPLES - n;
      if (n > RANDOM_SAMPLES * 4 / 5) calm = 1'b1;
      stream(total);
      n += total;
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("run covered %0d samples, %0d stencil results, %0d grid settings",
             samples_sent, sb.results_seen, settings_used);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[laplacian_4th_order_stencil_3d] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("[laplacian_4th_order_stencil_3d] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
sv/lap4_pkg.sv
sv/laplacian_4th_order_stencil_3d.sv
tb/laplacian_4th_order_stencil_3d_test.sv
